FILE: rtl/core/wba_pkg.sv
// ----------------------------------------------------------------------------
// wba_pkg
// Shared types, status codes and defaults for the wrapping block allocator.
// ----------------------------------------------------------------------------
package wba_pkg;

  localparam int BLOCKS_DEF     = 16;
  localparam int CMD_DEPTH_DEF  = 2;
  localparam int RES_DEPTH_DEF  = 2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_START   = 3'd1;
  localparam logic [2:0] ST_START_TAKEN = 3'd2;
  localparam logic [2:0] ST_NO_SPACE    = 3'd3;
  localparam logic [2:0] ST_EMPTY       = 3'd4;

  typedef struct packed {
    logic [5:0] start_block;
    logic [4:0] block_count;
    logic [7:0] owner_tag;
  } wba_in_t;

  typedef struct packed {
    logic [3:0] block_index;
    logic [2:0] status;
    logic [7:0] start_owner;
    logic       last;
  } wba_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] start_owner;
    logic [5:0] start_block;
    logic [4:0] block_count;
    logic [7:0] owner_tag;
  } wba_cmd_t;

  typedef struct packed {
    logic       idle;
    logic [7:0] rd_owner;
  } wba_back_stat_t;

endpackage

FILE: rtl/core/wba_fifo.sv
// ----------------------------------------------------------------------------
// wba_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module wba_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/wba_front.sv
// ----------------------------------------------------------------------------
// wba_front
// Accepts requests, waits for the back end to settle, then classifies each
// request against the block map and free count and queues a command.
// ----------------------------------------------------------------------------
module wba_front
  import wba_pkg::*;
#(
  parameter int BLOCKS = BLOCKS_DEF,
  localparam int AW    = $clog2(BLOCKS),
  localparam int FW    = $clog2(BLOCKS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  wba_in_t        in_data,
  output logic           in_full,
  input  logic [BLOCKS-1:0] taken_map,
  input  logic [FW-1:0]  free_cnt,
  input  wba_back_stat_t back_stat,
  input  logic           cmd_empty,
  output logic [AW-1:0]  rd_addr,
  output logic           cmd_push,
  output wba_cmd_t       cmd_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WAIT  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  localparam int CW = 7;

  logic [1:0]    state_r, state_nxt;
  wba_in_t       hold_r, hold_nxt;
  logic          accept;
  logic          settled;
  logic [AW-1:0] idx;

  assign in_full  = (state_r == S_WAIT);
  assign accept   = in_push && !in_full;
  // map and owner store stay still while nothing is queued or walking
  assign settled  = back_stat.idle && cmd_empty;
  assign idx      = hold_r.start_block[AW-1:0];
  assign rd_addr  = idx;
  assign cmd_push = (state_r == S_CHECK);
  assign hold_nxt = accept ? in_data : hold_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (settled) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = accept ? S_WAIT : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_data             = '0;
    cmd_data.start_block = hold_r.start_block;
    cmd_data.block_count = hold_r.block_count;
    cmd_data.owner_tag   = hold_r.owner_tag;
    if (CW'(hold_r.start_block) >= CW'(BLOCKS)) begin
      cmd_data.status = ST_BAD_START;
    end else if (taken_map[idx]) begin
      cmd_data.status      = ST_START_TAKEN;
      cmd_data.start_owner = back_stat.rd_owner;
    end else if (hold_r.block_count == '0) begin
      cmd_data.status = ST_EMPTY;
    end else if (CW'(hold_r.block_count) > CW'(free_cnt)) begin
      cmd_data.status = ST_NO_SPACE;
    end else begin
      cmd_data.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

FILE: rtl/core/wba_back.sv
// ----------------------------------------------------------------------------
// wba_back
// Carries out classified commands: emits status results or walks the block
// store one block per cycle unless the result queue is full, marking free blocks with the owner.
// ----------------------------------------------------------------------------
module wba_back
  import wba_pkg::*;
#(
  parameter int BLOCKS = BLOCKS_DEF,
  localparam int AW    = $clog2(BLOCKS),
  localparam int FW    = $clog2(BLOCKS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wba_cmd_t          cmd_data,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output logic              res_push,
  output wba_out_t          res_data,
  input  logic              res_full,
  input  logic [AW-1:0]     rd_addr,
  output logic [BLOCKS-1:0] taken_map,
  output logic [FW-1:0]     free_cnt,
  output wba_back_stat_t    back_stat
);

  logic              walk_r, walk_nxt;
  logic [AW-1:0]     pos_r, pos_nxt, pos_inc;
  logic [4:0]        left_r, left_nxt;
  logic [7:0]        own_r, own_nxt;
  logic [FW-1:0]     free_r, free_nxt;
  logic [BLOCKS-1:0] map_r, map_nxt;
  logic              mark;
  logic [7:0]        owner_mem [BLOCKS];
  logic [7:0]        rd_owner_r;

  assign taken_map          = map_r;
  assign free_cnt           = free_r;
  assign back_stat.idle     = !walk_r;
  assign back_stat.rd_owner = rd_owner_r;
  assign pos_inc = (pos_r == AW'(BLOCKS - 1)) ? '0 : pos_r + 1'b1;

  always_comb begin
    walk_nxt = walk_r;
    pos_nxt  = pos_r;
    left_nxt = left_r;
    own_nxt  = own_r;
    free_nxt = free_r;
    map_nxt  = map_r;
    mark     = 1'b0;
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    res_data = '0;
    if (walk_r) begin
      if (map_r[pos_r]) begin
        pos_nxt = pos_inc;
      end else if (!res_full) begin
        mark                 = 1'b1;
        res_push             = 1'b1;
        res_data.block_index = 4'(pos_r);
        res_data.status      = ST_OK;
        res_data.last        = (left_r == 5'd1);
        map_nxt[pos_r]       = 1'b1;
        free_nxt             = free_r - 1'b1;
        left_nxt             = left_r - 1'b1;
        pos_nxt              = pos_inc;
        if (left_r == 5'd1) begin
          walk_nxt = 1'b0;
        end
      end
    end else if (!cmd_empty && !res_full) begin
      cmd_pop = 1'b1;
      if (cmd_data.status == ST_OK) begin
        walk_nxt = 1'b1;
        pos_nxt  = cmd_data.start_block[AW-1:0];
        left_nxt = cmd_data.block_count;
        own_nxt  = cmd_data.owner_tag;
      end else begin
        // rejected or empty request: one status result
        res_push             = 1'b1;
        res_data.status      = cmd_data.status;
        res_data.start_owner = cmd_data.start_owner;
        res_data.last        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= 1'b0;
      free_r <= FW'(BLOCKS);
      map_r  <= '0;
    end else begin
      walk_r <= walk_nxt;
      free_r <= free_nxt;
      map_r  <= map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    left_r <= left_nxt;
    own_r  <= own_nxt;
  end

  always_ff @(posedge clk) begin
    if (mark) begin
      owner_mem[pos_r] <= own_r;
    end
    rd_owner_r <= owner_mem[rd_addr];
  end

endmodule

FILE: rtl/core/wrapping_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// wrapping_block_allocator_unit
// Block store allocator: requests take free blocks walking up from a start
// block with wraparound; each taken block is reported as one result.
// ----------------------------------------------------------------------------
//  channel  | ports                          | transaction
//  ---------+--------------------------------+------------------------------
//  request  | in_push, in_full, in_data      | in_push && !in_full
//  result   | out_pop, out_empty, out_data   | out_pop && !out_empty
//
//  a request is held and classified once the back end is idle and the
//  command queue is empty, so requests are handled one at a time
//  a rejected or empty request passes from the command queue through the
//  back end into the result queue as one status result
//  an allocating request walks the store one block per cycle, taken blocks
//  included, save that a free block waits while the result queue is full
//  reset clears the map to all free and empties both queues
//  a full result queue stalls the walk; a waiting request holds in_full high
// ----------------------------------------------------------------------------
module wrapping_block_allocator_unit
  import wba_pkg::*;
#(
  parameter int BLOCKS    = BLOCKS_DEF,
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  wba_in_t  in_data,
  output logic     in_full,
  input  logic     out_pop,
  output wba_out_t out_data,
  output logic     out_empty
);

  localparam int AW = $clog2(BLOCKS);
  localparam int FW = $clog2(BLOCKS + 1);

  logic              cmd_push, cmd_pop, cmd_empty, cmd_full;
  wba_cmd_t          cmd_wr, cmd_rd;
  logic              res_push, res_full;
  wba_out_t          res_wr;
  logic [AW-1:0]     rd_addr;
  logic [BLOCKS-1:0] taken_map;
  logic [FW-1:0]     free_cnt;
  wba_back_stat_t    back_stat;

  wba_front #(
    .BLOCKS (BLOCKS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .taken_map (taken_map),
    .free_cnt  (free_cnt),
    .back_stat (back_stat),
    .cmd_empty (cmd_empty),
    .rd_addr   (rd_addr),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wr)
  );

  wba_fifo #(
    .W     ($bits(wba_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  wba_back #(
    .BLOCKS (BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_rd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_wr),
    .res_full  (res_full),
    .rd_addr   (rd_addr),
    .taken_map (taken_map),
    .free_cnt  (free_cnt),
    .back_stat (back_stat)
  );

  wba_fifo #(
    .W     ($bits(wba_out_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

  // the front pushes only when the command queue is empty
  logic unused_cmd_full;
  assign unused_cmd_full = cmd_full;

endmodule
